// ===== sv/pwi_pkg.sv =====
// ----------------------------------------------------------------------------
// pwi_pkg: shared constants for the windowed-integral PID controller
// Field widths, register indexes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package pwi_pkg;

    // Parameter defaults
    localparam int WINDOW_LEN_DEF = 8;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed field widths
    localparam int DATA_W    = 16;
    localparam int GAIN_W    = 32;
    localparam int ACC_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT   = 2'd0,
        REG_GAIN_PROP  = 2'd1,
        REG_GAIN_INTEG = 2'd2,
        REG_GAIN_DERIV = 2'd3
    } t_cfg_reg;

    // Register reset values
    localparam logic signed [DATA_W-1:0] SETPOINT_RST   = 16'sd200;
    localparam logic        [GAIN_W-1:0] GAIN_PROP_RST  = 32'd65536;
    localparam logic        [GAIN_W-1:0] GAIN_INTEG_RST = 32'd655;
    localparam logic        [GAIN_W-1:0] GAIN_DERIV_RST = 32'd0;

endpackage

// ===== sv/pid_windowed_integral.sv =====
// ----------------------------------------------------------------------------
// pid_windowed_integral: fixed-point PID controller, sliding-window integral
//
// Input channel: i_valid / o_stall carry one measured temperature per
// transfer. Output channel: o_valid / i_stall carry the drive value and the
// error for that sample, one result per input, in order.
// The result passes three registered stages from input transfer to result
// valid: error and window update, the three gain multiplies, then the sum and the Q scaling.
// Throughput is one sample per cycle; the three pipeline stages advance
// together whenever the result register is empty or being taken.
// When the receiver stalls, the pipeline holds and o_stall rises in the same
// cycle, so no result is lost; upstream may keep valid high and wait.
// The error history is a shift line of WINDOW_LEN previous errors plus a
// running total; it is updated at the input transfer, so samples may follow
// each other with no gap.
// Reset (synchronous, active low) restores the register defaults and
// clears the history, running total, previous error and all stage valids.
// Configuration writes take effect on the next cycle and belong between
// bursts, with the pipeline empty.
// ----------------------------------------------------------------------------
module pid_windowed_integral #(
    parameter int WINDOW_LEN = pwi_pkg::WINDOW_LEN_DEF,
    parameter int FRAC_BITS  = pwi_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [pwi_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pwi_pkg::CFG_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [pwi_pkg::DATA_W-1:0]   i_measured_temp,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [pwi_pkg::DATA_W-1:0]   o_drive_value,
    output logic signed [pwi_pkg::DATA_W-1:0]   o_current_error
);
    import pwi_pkg::*;

    localparam int WIN_W   = DATA_W + $clog2(WINDOW_LEN);
    localparam int DELTA_W = DATA_W + 1;
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);

    // Configuration registers
    logic signed [DATA_W-1:0] r_setpoint;
    logic        [GAIN_W-1:0] r_gain_prop;
    logic        [GAIN_W-1:0] r_gain_integ;
    logic        [GAIN_W-1:0] r_gain_deriv;

    // History state
    logic signed [DATA_W-1:0] r_hist [WINDOW_LEN];
    logic signed [DATA_W-1:0] r_last_err;
    logic signed [WIN_W-1:0]  r_win;

    // Pipeline
    logic                      r_v1, r_v2, r_v3;
    logic signed [DATA_W-1:0]  r_s1_err, r_s2_err;
    logic signed [WIN_W-1:0]   r_s1_win;
    logic signed [DELTA_W-1:0] r_s1_delta;
    logic        [ACC_W-1:0]   r_s2_prop, r_s2_integ, r_s2_deriv;
    logic signed [DATA_W-1:0]  r_out_drive, r_out_err;

    logic                      adv;
    logic                      in_xfer;
    logic signed [DATA_W-1:0]  n_err;
    logic signed [WIN_W-1:0]   n_win;
    logic signed [DELTA_W-1:0] n_delta;
    logic        [ACC_W-1:0]   n_prop, n_integ, n_deriv;
    logic        [ACC_W-1:0]   acc_sum;
    logic        [ACC_W-1:0]   acc_biased;
    logic signed [ACC_W-1:0]   acc_quot;

    assign adv     = !r_v3 || !i_stall;
    assign o_stall = !adv;
    assign in_xfer = i_valid && adv;

    // Stage 1: error, window update, derivative
    assign n_err   = r_setpoint - i_measured_temp;
    assign n_win   = r_win - WIN_W'(r_hist[WINDOW_LEN-1]) + WIN_W'(r_last_err);
    assign n_delta = DELTA_W'(n_err) - DELTA_W'(r_last_err);

    // Stage 2: products modulo 2^32
    assign n_prop  = r_gain_prop  * ACC_W'(r_s1_err);
    assign n_integ = r_gain_integ * ACC_W'(r_s1_win);
    assign n_deriv = r_gain_deriv * ACC_W'(r_s1_delta);

    // Stage 3: sum and scale, truncating toward zero
    assign acc_sum    = r_s2_prop + r_s2_integ + r_s2_deriv;
    assign acc_biased = acc_sum[ACC_W-1] ? acc_sum + ROUND_BIAS : acc_sum;
    assign acc_quot   = $signed(acc_biased) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint   <= SETPOINT_RST;
            r_gain_prop  <= GAIN_PROP_RST;
            r_gain_integ <= GAIN_INTEG_RST;
            r_gain_deriv <= GAIN_DERIV_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_SETPOINT:   r_setpoint   <= DATA_W'(i_cfg_data);
                REG_GAIN_PROP:  r_gain_prop  <= GAIN_W'(i_cfg_data);
                REG_GAIN_INTEG: r_gain_integ <= GAIN_W'(i_cfg_data);
                REG_GAIN_DERIV: r_gain_deriv <= GAIN_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Shift the previous error into the window on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_hist[k] <= '0;
            end
            r_last_err <= '0;
            r_win      <= '0;
        end else if (in_xfer) begin
            r_hist[0] <= r_last_err;
            for (int k = 1; k < WINDOW_LEN; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
            r_last_err <= n_err;
            r_win      <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_err    <= n_err;
            r_s1_win    <= n_win;
            r_s1_delta  <= n_delta;
            r_s2_err    <= r_s1_err;
            r_s2_prop   <= n_prop;
            r_s2_integ  <= n_integ;
            r_s2_deriv  <= n_deriv;
            r_out_err   <= r_s2_err;
            r_out_drive <= acc_quot[DATA_W-1:0];
        end
    end

    assign o_valid         = r_v3;
    assign o_drive_value   = r_out_drive;
    assign o_current_error = r_out_err;

endmodule
